>>> hdl/three_level_priority_queue_macros.svh
// Assertion macros for the priority queue RTL.
// No dependencies; included by three_level_priority_queue.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_MACROS_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// Check prop on every rising clock edge, ignored while rst is high.
`define TLPQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
// Check prop on every rising clock edge, reset included.
`define TLPQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("%m: assertion failed");
`else
`define TLPQ_ASSERT(label, clk, rst, prop)
`define TLPQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hdl/tlpq_pkg.sv
// Types and constants of the three-level priority queue.
// No dependencies; imported by tlpq_cell and three_level_priority_queue.
`timescale 1ns / 1ps
package tlpq_pkg;

   localparam int TAG_W = 16;
   localparam int PRI_W = 2;
   localparam int OCC_W = 8;

   localparam logic [PRI_W-1:0] PRI_GENERAL = 2'd2;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } tlpq_status_type;

   typedef enum logic {
      REQ_ENQUEUE = 1'b0,
      REQ_DEQUEUE = 1'b1
   } tlpq_kind_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [PRI_W-1:0] pri;
   } tlpq_entry_type;

   // What one cell shows its neighbors.
   typedef struct packed {
      tlpq_entry_type entry;
      logic           greater;   // occupied and less urgent than the new entry
   } tlpq_link_type;

   // Command broadcast to every cell.
   typedef struct packed {
      logic           enq;
      logic           deq;
      tlpq_entry_type new_entry;
   } tlpq_cmd_type;

   localparam tlpq_link_type LINK_NONE = '0;

endpackage

>>> hdl/tlpq_cell.sv
// One slot of the sorted shift chain: holds an entry, compares it with the
// entry being inserted and shifts to/from its neighbors. Depends on tlpq_pkg.
`timescale 1ns / 1ps
module tlpq_cell
   import tlpq_pkg::*;
#(
   parameter int CNT_W = 8,
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic [CNT_W-1:0] count,
   input  tlpq_cmd_type     cmd,
   input  tlpq_link_type    left,
   input  tlpq_link_type    right,
   output tlpq_link_type    link
);

   tlpq_entry_type entry_ff;
   tlpq_entry_type entry_in;
   logic           occupied;
   logic           tail;
   logic           greater;

   assign occupied = count > CNT_W'(INDEX);
   assign tail     = count == CNT_W'(INDEX);
   assign greater  = occupied && (entry_ff.pri > cmd.new_entry.pri);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq) begin
         // left neighbor moving back takes priority, then the insert point
         if (left.greater) begin
            entry_in = left.entry;
         end else if (greater || tail) begin
            entry_in = cmd.new_entry;
         end
      end else if (cmd.deq) begin
         entry_in = right.entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign link.entry   = entry_ff;
   assign link.greater = greater;

endmodule

>>> hdl/three_level_priority_queue.sv
// Top level of the three-level priority queue: request/response channels,
// entry count and the chain of tlpq_cell slots. Depends on tlpq_pkg,
// tlpq_cell and three_level_priority_queue_macros.svh.
//
// Bounded, stable priority queue of up to DEPTH entries, level 0 the most
// urgent. Each request transfer is either an enqueue (tag and priority in
// req_tdata) or a dequeue (req_tuser = 1) and yields exactly one response,
// presented in the cycle after the request transfer and held until taken. It
// carries a status, the served entry on a successful dequeue, and the
// occupancy after the request. An enqueue lands
// behind every stored entry of equal or higher urgency, so each level is
// first in, first out; priority 3 is treated as 2. Enqueue on a full queue
// and dequeue on an empty one leave the store untouched and report status 1
// and 2. The entries live in a row of DEPTH cells, each comparing its own
// priority with the incoming one; all cells shift in the same clock, so a
// new request is taken in every cycle as long as the response register is
// free or being drained. The response register decouples the two sides: a
// request is taken whenever the pending response is taken in the same
// cycle. Occupancy reads the count modulo 256. There is no clearing pass;
// the block is ready right after reset.
`timescale 1ns / 1ps
`include "three_level_priority_queue_macros.svh"
module three_level_priority_queue
   import tlpq_pkg::*;
#(
   parameter int DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] entry_tag, [17:16] entry_priority, rest 0
   input  logic [0:0]  req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [1:0] status, [17:2] served_tag,
                                    // [19:18] served_priority, [27:20] occupancy
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [31:0]      rsp_data_ff;
   logic [31:0]      rsp_data_in;

   logic             req_fire;
   tlpq_kind_type    kind;
   logic [PRI_W-1:0] raw_pri;
   logic             is_full;
   logic             is_empty;
   tlpq_cmd_type     cmd;
   tlpq_link_type    cell_link [DEPTH];

   tlpq_status_type  status;
   tlpq_entry_type   served;
   logic [CNT_W+OCC_W-1:0] count_ext;

   // Accept while the response register is empty or being drained.
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign kind     = tlpq_kind_type'(req_tuser[0]);
   assign raw_pri  = req_tdata[TAG_W +: PRI_W];
   assign is_full  = count_ff == CNT_W'(DEPTH);
   assign is_empty = count_ff == '0;

   // Saturate priority 3 to general.
   assign cmd.new_entry.tag = req_tdata[TAG_W-1:0];
   assign cmd.new_entry.pri = (raw_pri > PRI_GENERAL) ? PRI_GENERAL : raw_pri;
   assign cmd.enq = req_fire && (kind == REQ_ENQUEUE) && !is_full;
   assign cmd.deq = req_fire && (kind == REQ_DEQUEUE) && !is_empty;

   // Row of slots, head at index 0.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      tlpq_link_type left_link;
      tlpq_link_type right_link;
      if (i == 0) begin : g_head
         assign left_link = LINK_NONE;
      end else begin : g_mid_l
         assign left_link = cell_link[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_link = cell_link[i];
      end else begin : g_mid_r
         assign right_link = cell_link[i+1];
      end
      tlpq_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock (clock),
         .count (count_ff),
         .cmd   (cmd),
         .left  (left_link),
         .right (right_link),
         .link  (cell_link[i])
      );
   end

   // Count update and response build.
   always_comb begin
      count_in = count_ff;
      status   = ST_DONE;
      served   = '{tag: '0, pri: PRI_GENERAL};
      priority if (cmd.enq) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.deq) begin
         count_in = count_ff - 1'b1;
         served   = cell_link[0].entry;
      end else if (kind == REQ_ENQUEUE) begin
         status = ST_FULL;
      end else begin
         status = ST_EMPTY;
      end
   end

   assign count_ext = {{OCC_W{1'b0}}, count_in};

   assign rsp_data_in = {4'b0, count_ext[OCC_W-1:0], served.pri, served.tag, status};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: load on every accepted request.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Count never exceeds the store size.
   `TLPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   // A dequeue on a non-empty queue drops the count by one.
   `TLPQ_ASSERT(a_deq_count, clock, reset,
      (req_fire && kind == REQ_DEQUEUE && !is_empty) |=> count_ff == $past(count_ff) - 1'b1)
   // An enqueue on a full queue reports full and leaves the count alone.
   `TLPQ_ASSERT(a_full_reject, clock, reset,
      (req_fire && kind == REQ_ENQUEUE && is_full) |=>
      (rsp_tdata[1:0] == ST_FULL && count_ff == $past(count_ff)))
   // An empty-queue response always goes with an empty store.
   `TLPQ_ASSERT(a_empty_rsp, clock, reset,
      (rsp_tvalid && rsp_tdata[1:0] == ST_EMPTY && !$past(cmd.enq)) |-> count_ff == '0)

endmodule

>>> test/testbench.sv
// Self-checking testbench for three_level_priority_queue: directed and random
// enqueue/dequeue traffic, each response checked against an in-bench model.
// Depends on tlpq_pkg and the three_level_priority_queue RTL.
`timescale 1ns / 1ps
module testbench;
   import tlpq_pkg::*;

   localparam int QUEUE_DEPTH   = 128;
   localparam int HALF_PERIOD   = 6;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PRINT_LIMIT   = 50;

   // What one response transfer should carry.
   typedef struct {
      tlpq_status_type  status;
      logic [TAG_W-1:0] tag;
      logic [PRI_W-1:0] pri;
      logic [OCC_W-1:0] occupancy;
   } outcome_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [15:0] entry_tag, [17:16] entry_priority, rest 0
   logic [0:0]  req_tuser  = '0;   // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [1:0] status, [17:2] served_tag,
                                   // [19:18] served_priority, [27:20] occupancy

   // Model of the store, head first, and responses still owed by the block.
   tlpq_entry_type waiting_line[$];
   outcome_type    expected_outcomes[$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   bit rx_stalls_on   = 1'b1;
   bit tx_gaps_on     = 1'b1;
   int rx_hold_left   = 0;

   three_level_priority_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Stop a hung run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pause_length();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // Apply one request to the model of the store and return its response.
   function automatic outcome_type predict_service(logic [0:0] kind,
                                                   logic [TAG_W-1:0] tag,
                                                   logic [PRI_W-1:0] pri);
      outcome_type    result;
      tlpq_entry_type entry;
      int             slot;
      result.status = ST_DONE;
      result.tag    = '0;
      result.pri    = PRI_GENERAL;
      if (kind == REQ_ENQUEUE) begin
         entry.tag = tag;
         // priority three counts as general
         entry.pri = (pri > PRI_GENERAL) ? PRI_GENERAL : pri;
         if (waiting_line.size() >= QUEUE_DEPTH) begin
            result.status = ST_FULL;
         end else begin
            // land behind every entry that is as urgent or more
            slot = waiting_line.size();
            while (slot > 0 && waiting_line[slot-1].pri > entry.pri)
               slot--;
            waiting_line.insert(slot, entry);
         end
      end else if (waiting_line.size() == 0) begin
         result.status = ST_EMPTY;
      end else begin
         entry      = waiting_line.pop_front();
         result.tag = entry.tag;
         result.pri = entry.pri;
      end
      result.occupancy = OCC_W'(waiting_line.size());
      return result;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
   endtask

   // Receiver: randomly withhold rsp_tready, with stretches of none.
   always @(posedge clock) begin
      if (rx_hold_left > 0) begin
         rx_hold_left = rx_hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
         rx_hold_left = pause_length() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check every response transfer against the oldest expectation, then
   // predict the response of any request transfer at the same edge.
   always @(posedge clock) begin : watch_transfers
      outcome_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("response with none pending", rsp_tdata, 0);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_tdata[1:0] !== want.status)
                  report_mismatch("status", rsp_tdata[1:0], want.status);
               if (rsp_tdata[17:2] !== want.tag)
                  report_mismatch("served_tag", rsp_tdata[17:2], want.tag);
               if (rsp_tdata[19:18] !== want.pri)
                  report_mismatch("served_priority", rsp_tdata[19:18], want.pri);
               if (rsp_tdata[27:20] !== want.occupancy)
                  report_mismatch("occupancy", rsp_tdata[27:20], want.occupancy);
            end
         end
         if (req_tvalid && req_tready)
            expected_outcomes.push_back(predict_service(req_tuser, req_tdata[15:0],
                                                        req_tdata[17:16]));
      end
   end

   // Offer one request and hold it until the transfer; then maybe drop
   // valid for a while. Called on a rising edge.
   task automatic send_request(tlpq_kind_type kind, logic [TAG_W-1:0] tag,
                               logic [PRI_W-1:0] pri);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'd0, pri, tag};
      do @(posedge clock); while (!req_tready);
      gap = (tx_gaps_on && $urandom_range(0, 1) == 0) ? pause_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off the sender until every owed response has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_outcomes.size() != 0);
   endtask

   task automatic send_random(int enqueue_weight);
      tlpq_kind_type kind;
      kind = ($urandom_range(0, 3) < enqueue_weight) ? REQ_ENQUEUE : REQ_DEQUEUE;
      send_request(kind, TAG_W'($urandom), PRI_W'($urandom_range(0, 3)));
   endtask

   // Dequeue on an empty queue; the tag and priority fields are ignored.
   task automatic test_empty_queue();
      send_request(REQ_DEQUEUE, 16'hFFFF, 2'd3);
      send_request(REQ_DEQUEUE, 16'h0000, 2'd0);
   endtask

   // Every level, saturated priority three, tag extremes, FIFO order within
   // a level; drain to one past empty.
   task automatic test_level_order();
      send_request(REQ_ENQUEUE, 16'hFFFF, 2'd2);
      send_request(REQ_ENQUEUE, 16'h0000, 2'd0);
      send_request(REQ_ENQUEUE, 16'h1234, 2'd1);
      send_request(REQ_ENQUEUE, 16'hA5A5, 2'd3);
      send_request(REQ_ENQUEUE, 16'h5A5A, 2'd0);
      send_request(REQ_ENQUEUE, 16'h00FF, 2'd1);
      send_request(REQ_ENQUEUE, 16'hFF00, 2'd2);
      repeat (8) send_request(REQ_DEQUEUE, TAG_W'($urandom), 2'd0);
   endtask

   // Fill to the brim, knock on a full queue, then drain past empty.
   task automatic test_full_store();
      int fill;
      wait_drained();
      fill = QUEUE_DEPTH - waiting_line.size() + 5;
      repeat (fill) send_random(4);
      repeat (QUEUE_DEPTH + 3) send_random(0);
   endtask

   // Phases of mixed traffic with a drifting enqueue bias, idling toggled.
   task automatic test_random_traffic();
      int weight;
      for (int phase = 0; phase < 10; phase++) begin
         weight       = $urandom_range(1, 3);
         rx_stalls_on = ($urandom_range(0, 3) != 0);
         tx_gaps_on   = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(30, 45)) send_random(weight);
         if (phase % 4 == 3)
            wait_drained();
      end
      rx_stalls_on = 1'b1;
      tx_gaps_on   = 1'b1;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_level_order();
      test_full_store();
      test_random_traffic();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_outcomes.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> three_level_priority_queue.f
+incdir+hdl
hdl/tlpq_pkg.sv
hdl/tlpq_cell.sv
hdl/three_level_priority_queue.sv
test/testbench.sv
